// File: hdl/xyma_pkg.sv
// shared constants, codes and controller/datapath signal groups for the xy moving average
// no dependencies
`default_nettype none

package xyma_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int SPAN_REG_W       = 7;
    localparam int SPAN_RESET       = 3;
    localparam int INDEX_W          = 32;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_W        = 2;

    localparam logic [REG_IDX_W-1:0] REG_SPAN    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_AVG_X   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_INDEX = 2'd2;

    typedef struct packed {
        logic accept;
        logic read;
        logic update;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic need_div;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: hdl/xyma_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module xyma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hdl/xyma_div.sv
// two-lane bit-serial signed divider, one quotient bit per cycle, truncates toward zero
// no dependencies
`default_nettype none

module xyma_div #(
    parameter int SUM_W  = 38,
    parameter int SPAN_W = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic        [SPAN_W-1:0] i_divisor,
    input  wire logic signed [SUM_W-1:0]  i_dividend [2],
    output logic                          o_busy,
    output logic signed      [SUM_W-1:0]  o_quotient [2]
);

    localparam int CNT_W = $clog2(SUM_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [SPAN_W-1:0]   r_divisor;
    logic                r_neg [2];
    logic [SPAN_W-1:0]   r_rem [2];
    logic [SUM_W-1:0]    r_quo [2];
    logic [SPAN_W-1:0]   n_rem [2];
    logic [SUM_W-1:0]    n_quo [2];
    logic [SPAN_W:0]     w_trial [2];
    logic                w_ge [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_trial[l] = {r_rem[l], r_quo[l][SUM_W-1]};
            w_ge[l]    = (w_trial[l] >= {1'b0, r_divisor});
            n_rem[l]   = w_ge[l] ? SPAN_W'(w_trial[l] - {1'b0, r_divisor})
                                 : SPAN_W'(w_trial[l]);
            n_quo[l]   = {r_quo[l][SUM_W-2:0], w_ge[l]};
            o_quotient[l] = r_neg[l] ? -$signed(r_quo[l]) : $signed(r_quo[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            for (int l = 0; l < 2; l++) begin
                r_neg[l] <= i_dividend[l][SUM_W-1];
                r_rem[l] <= '0;
                r_quo[l] <= i_dividend[l][SUM_W-1] ? SUM_W'(-i_dividend[l])
                                                    : SUM_W'(i_dividend[l]);
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= n_rem[l];
                r_quo[l] <= n_quo[l];
            end
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// File: hdl/xyma_ctrl.sv
// controller state machine: sequences accept, ring read, update, divide and result load
// depends on xyma_pkg
`default_nettype none

module xyma_ctrl import xyma_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_DSTART = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (!i_status.due) begin
                    n_state = S_IDLE;
                end else if (i_status.need_div) begin
                    n_state = S_DSTART;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// File: hdl/xyma_dp.sv
// datapath: sample index, ring buffers, running sums, refill countdown, divider, result register
// depends on xyma_pkg, xyma_ram, xyma_div
`default_nettype none

module xyma_dp import xyma_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int SPAN_W       = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cmd                           i_cmd,
    output t_status                             o_status,
    input  wire logic        [SPAN_W-1:0]       i_span,
    input  wire logic                           i_avg_x,
    input  wire logic                           i_x_index,
    input  wire logic                           i_cfg_restart,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_sample,
    input  wire logic                           i_x_ok,
    input  wire logic                           i_y_ok,
    input  wire logic                           i_series_start,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic signed      [SAMPLE_WIDTH-1:0] o_x_out,
    output logic signed      [SAMPLE_WIDTH-1:0] o_y_out,
    output logic                                o_x_out_ok,
    output logic                                o_y_out_ok
);

    localparam int SLOT_W    = $clog2(WINDOW_MAX);
    localparam int SUM_W     = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
    localparam int EXT_W     = SUM_W - SAMPLE_WIDTH;
    localparam int SPAN_RST  = (SPAN_RESET > WINDOW_MAX) ? WINDOW_MAX : SPAN_RESET;

    logic [INDEX_W-1:0]             r_index;
    logic [SLOT_W-1:0]              r_slot;
    logic [SPAN_W-1:0]              r_refill;
    logic signed [SUM_W-1:0]        r_xsum;
    logic signed [SUM_W-1:0]        r_ysum;
    logic signed [SAMPLE_WIDTH-1:0] r_xv;
    logic signed [SAMPLE_WIDTH-1:0] r_yv;
    logic                           r_valid;
    logic                           r_due;
    logic                           r_xok;
    logic                           r_yok;
    logic                           r_out_valid;

    logic [INDEX_W-1:0]             w_idx;
    logic [INDEX_W+SAMPLE_WIDTH-1:0] w_idx_ext;
    logic                           w_restart;
    logic [SPAN_W:0]                w_rs_t;
    logic [SPAN_W:0]                w_rs;
    logic [SAMPLE_WIDTH-1:0]        w_x_old;
    logic [SAMPLE_WIDTH-1:0]        w_y_old;
    logic signed [SUM_W-1:0]        w_x_old_ext;
    logic signed [SUM_W-1:0]        w_y_old_ext;
    logic signed [SUM_W-1:0]        w_xv_ext;
    logic signed [SUM_W-1:0]        w_yv_ext;
    logic signed [SUM_W-1:0]        n_xsum;
    logic signed [SUM_W-1:0]        n_ysum;
    logic [SPAN_W-1:0]              n_refill;
    logic                           w_full;
    logic                           w_wr_en;
    logic signed [SUM_W-1:0]        w_dividend [2];
    logic signed [SUM_W-1:0]        w_quotient [2];
    logic                           w_div_busy;

    // index and window restart as seen by the sample being accepted
    assign w_idx     = i_series_start ? '0 : r_index;
    assign w_idx_ext = (INDEX_W + SAMPLE_WIDTH)'(w_idx);
    assign w_restart = i_cfg_restart || (i_cmd.accept && i_series_start);

    // oldest entry of the window: slot - span, wrapped
    assign w_rs_t = (SPAN_W + 1)'(r_slot) + (SPAN_W + 1)'(WINDOW_MAX) - (SPAN_W + 1)'(i_span);
    assign w_rs   = (w_rs_t >= (SPAN_W + 1)'(WINDOW_MAX)) ? w_rs_t - (SPAN_W + 1)'(WINDOW_MAX)
                                                            : w_rs_t;

    assign w_x_old_ext = {{EXT_W{w_x_old[SAMPLE_WIDTH-1]}}, w_x_old};
    assign w_y_old_ext = {{EXT_W{w_y_old[SAMPLE_WIDTH-1]}}, w_y_old};
    assign w_xv_ext    = {{EXT_W{r_xv[SAMPLE_WIDTH-1]}}, r_xv};
    assign w_yv_ext    = {{EXT_W{r_yv[SAMPLE_WIDTH-1]}}, r_yv};

    always_comb begin
        if (r_refill == '0) begin
            n_xsum   = r_xsum + w_xv_ext - w_x_old_ext;
            n_ysum   = r_ysum + w_yv_ext - w_y_old_ext;
            n_refill = '0;
        end else begin
            n_xsum   = r_xsum + w_xv_ext;
            n_ysum   = r_ysum + w_yv_ext;
            n_refill = r_refill - 1'b1;
        end
    end

    assign w_full  = r_valid && (n_refill == '0);
    assign w_wr_en = i_cmd.update && r_valid;

    xyma_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_x_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_xv),
        .i_rd_en   (i_cmd.read),
        .i_rd_addr (w_rs[SLOT_W-1:0]),
        .o_rd_data (w_x_old)
    );

    xyma_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_y_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_yv),
        .i_rd_en   (i_cmd.read),
        .i_rd_addr (w_rs[SLOT_W-1:0]),
        .o_rd_data (w_y_old)
    );

    assign w_dividend[0] = r_xsum;
    assign w_dividend[1] = r_ysum;

    xyma_div #(
        .SUM_W  (SUM_W),
        .SPAN_W (SPAN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (i_span),
        .i_dividend (w_dividend),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_slot      <= '0;
            r_refill    <= SPAN_W'(SPAN_RST);
            r_xsum      <= '0;
            r_ysum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_index <= (w_idx == '1) ? w_idx : w_idx + 1'b1;
                if (i_series_start) begin
                    r_slot <= '0;
                end
            end
            if (w_restart) begin
                r_xsum   <= '0;
                r_ysum   <= '0;
                r_refill <= i_span;
            end else if (i_cmd.update) begin
                if (r_valid) begin
                    r_xsum   <= n_xsum;
                    r_ysum   <= n_ysum;
                    r_refill <= n_refill;
                    r_slot   <= (r_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : r_slot + 1'b1;
                end else begin
                    r_xsum   <= '0;
                    r_ysum   <= '0;
                    r_refill <= i_span;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-sample payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_xv    <= i_x_index ? $signed(w_idx_ext[SAMPLE_WIDTH-1:0]) : i_x_sample;
            r_yv    <= i_y_sample;
            r_valid <= (i_x_index || i_x_ok) && i_y_ok;
            r_due   <= (({1'b0, w_idx} + (INDEX_W + 1)'(1)) >= (INDEX_W + 1)'(i_span));
        end
        if (i_cmd.update) begin
            r_xok <= r_valid && (!i_avg_x || w_full);
            r_yok <= w_full;
        end
        if (i_cmd.load_out) begin
            o_x_out_ok <= r_xok;
            o_y_out_ok <= r_yok;
            o_x_out    <= !r_xok ? '0 :
                          i_avg_x ? $signed(w_quotient[0][SAMPLE_WIDTH-1:0]) : r_xv;
            o_y_out    <= r_yok ? $signed(w_quotient[1][SAMPLE_WIDTH-1:0]) : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.due      = r_due;
    assign o_status.need_div = w_full;
    assign o_status.div_busy = w_div_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// File: hdl/xy_moving_average.sv
// top level of the xy moving average: configuration registers, controller and datapath
// depends on xyma_pkg, xyma_ctrl, xyma_dp
//
//   port group      direction  transfer when
//   sample input    in         i_in_valid && o_in_ready
//   result output   out        o_out_valid && i_out_ready
//   configuration   in/out     psel && penable && pwrite && pready
//
// one sample at a time; a sample that produces an average waits on the bit-serial divider,
// which gives one quotient bit a cycle for the x and y sums together; a result with no
// average to compute skips the divider, and a sample that gives no result loads nothing
// the result register lets the next sample in while the last result waits
// a stalled result holds the controller before loading, never the accepted sample
// synchronous active-low reset; ring contents stay unknown until written
`default_nettype none

module xy_moving_average import xyma_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_sample,
    input  wire logic                           i_x_ok,
    input  wire logic                           i_y_ok,
    input  wire logic                           i_series_start,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0] o_x_out,
    output logic signed      [SAMPLE_WIDTH-1:0] o_y_out,
    output logic                                o_x_out_ok,
    output logic                                o_y_out_ok,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [APB_ADDR_W-1:0]          paddr,
    input  wire logic [APB_DATA_W-1:0]          pwdata,
    output logic      [APB_DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int SPAN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (SPAN_W > SPAN_REG_W) ? SPAN_W : SPAN_REG_W;

    logic [SPAN_REG_W-1:0] r_span;
    logic                  r_avg_x;
    logic                  r_x_index;
    logic                  r_cfg_restart;

    logic                  w_wr;
    logic [REG_IDX_W-1:0]  w_reg_idx;
    logic [CMP_W-1:0]      w_span_ext;
    logic [CMP_W-1:0]      w_span_clamp;
    logic [SPAN_W-1:0]     w_span;
    t_cmd                  w_cmd;
    t_status               w_status;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span        <= SPAN_REG_W'(SPAN_RESET);
            r_avg_x       <= 1'b1;
            r_x_index     <= 1'b0;
            r_cfg_restart <= 1'b0;
        end else begin
            r_cfg_restart <= 1'b0;
            if (w_wr) begin
                case (w_reg_idx)
                    REG_SPAN: begin
                        r_span        <= pwdata[SPAN_REG_W-1:0];
                        r_cfg_restart <= 1'b1;
                    end
                    REG_AVG_X: begin
                        r_avg_x <= pwdata[0];
                    end
                    REG_X_INDEX: begin
                        r_x_index     <= pwdata[0];
                        r_cfg_restart <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SPAN:    prdata = APB_DATA_W'(r_span);
            REG_AVG_X:   prdata = APB_DATA_W'(r_avg_x);
            REG_X_INDEX: prdata = APB_DATA_W'(r_x_index);
            default:     prdata = '0;
        endcase
    end

    // span in use, clamped to [2, WINDOW_MAX]
    assign w_span_ext   = CMP_W'(r_span);
    assign w_span_clamp = (w_span_ext < CMP_W'(2))          ? CMP_W'(2) :
                          (w_span_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : w_span_ext;
    assign w_span       = w_span_clamp[SPAN_W-1:0];

    xyma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    xyma_dp #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SPAN_W       (SPAN_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_span         (w_span),
        .i_avg_x        (r_avg_x),
        .i_x_index      (r_x_index),
        .i_cfg_restart  (r_cfg_restart),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_x_ok         (i_x_ok),
        .i_y_ok         (i_y_ok),
        .i_series_start (i_series_start),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_x_out_ok     (o_x_out_ok),
        .o_y_out_ok     (o_y_out_ok)
    );

`ifndef NO_ASSERTIONS
    a_div_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_busy |-> !o_in_ready)
        else $error("divider busy while controller idle");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("result valid without a load");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second sample taken while one is in work");
`endif

endmodule

`default_nettype wire

// File: dv/xyma_checker.sv
// checker for the xy moving average: watches the sample, result and register transfers,
// keeps its own copy of the window state and compares every result with its prediction
// depends on xyma_pkg
module xyma_checker import xyma_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y_sample,
    input  logic                           i_x_ok,
    input  logic                           i_y_ok,
    input  logic                           i_series_start,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x_out,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y_out,
    input  logic                           i_x_out_ok,
    input  logic                           i_y_out_ok,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_W-1:0]          paddr,
    input  logic [APB_DATA_W-1:0]          pwdata,
    input  logic                           pready,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic                           x_ok;
        logic                           y_ok;
    } t_avg_result;

    t_avg_result                    averages_due[$];
    logic signed [SAMPLE_WIDTH-1:0] x_ring [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] y_ring [WINDOW_MAX];
    longint                         x_sum;
    longint                         y_sum;
    int unsigned                    refill_left;
    int unsigned                    write_slot;
    logic [INDEX_W-1:0]             sample_index;
    logic [SPAN_REG_W-1:0]          span_reg;
    logic                           avg_x_mode;
    logic                           index_x_mode;
    int                             checked_count;
    int                             error_count;

    function automatic int unsigned span_in_use();
        int unsigned span;
        span = span_reg;
        if (span < 2) span = 2;
        if (span > WINDOW_MAX) span = WINDOW_MAX;
        return span;
    endfunction

    task automatic restart_window();
        x_sum       = 0;
        y_sum       = 0;
        refill_left = span_in_use();
    endtask

    task automatic reset_window_state();
        span_reg     = SPAN_REG_W'(SPAN_RESET);
        avg_x_mode   = 1'b1;
        index_x_mode = 1'b0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            x_ring[i] = '0;
            y_ring[i] = '0;
        end
        sample_index = '0;
        write_slot   = 0;
        averages_due.delete();
        restart_window();
    endtask

    task automatic apply_reg_write(input logic [REG_IDX_W-1:0] idx,
                                   input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_SPAN: begin
                span_reg = value[SPAN_REG_W-1:0];
                restart_window();
            end
            REG_AVG_X: begin
                avg_x_mode = value[0];
            end
            REG_X_INDEX: begin
                index_x_mode = value[0];
                restart_window();
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_average(input logic signed [SAMPLE_WIDTH-1:0] x_in,
                                   input logic signed [SAMPLE_WIDTH-1:0] y_in,
                                   input logic x_ok_in, input logic y_ok_in,
                                   input logic start);
        int unsigned                    span;
        int unsigned                    slot;
        int unsigned                    old_slot;
        logic [INDEX_W-1:0]             idx;
        logic signed [SAMPLE_WIDTH-1:0] xv;
        logic                           sample_good;
        logic                           due;
        longint                         quotient;
        t_avg_result                    res;
        if (start) begin
            sample_index = '0;
            write_slot   = 0;
            restart_window();
        end
        span = span_in_use();
        idx  = sample_index;
        if (sample_index != '1) sample_index = sample_index + 1'b1;
        due = (longint'(idx) + 1 >= longint'(span));

        xv          = index_x_mode ? SAMPLE_WIDTH'(idx) : x_in;
        sample_good = (index_x_mode || x_ok_in) && y_ok_in;
        res         = '0;

        if (!sample_good) begin
            restart_window();
        end else begin
            slot = write_slot % WINDOW_MAX;
            if (refill_left == 0) begin
                old_slot = (slot + WINDOW_MAX - span) % WINDOW_MAX;
                x_sum    = x_sum - x_ring[old_slot];
                y_sum    = y_sum - y_ring[old_slot];
            end else begin
                refill_left = refill_left - 1;
            end
            x_ring[slot] = xv;
            y_ring[slot] = y_in;
            write_slot   = (slot + 1) % WINDOW_MAX;
            x_sum        = x_sum + xv;
            y_sum        = y_sum + y_in;

            if (avg_x_mode) begin
                if (refill_left == 0) begin
                    quotient = x_sum / longint'(span);
                    res.x    = quotient[SAMPLE_WIDTH-1:0];
                    res.x_ok = 1'b1;
                end
            end else begin
                res.x    = xv;
                res.x_ok = 1'b1;
            end
            if (refill_left == 0) begin
                quotient = y_sum / longint'(span);
                res.y    = quotient[SAMPLE_WIDTH-1:0];
                res.y_ok = 1'b1;
            end
        end
        if (due) averages_due.push_back(res);
    endtask

    task automatic check_average();
        t_avg_result want;
        if (averages_due.size() == 0) begin
            $error("unexpected result transfer: x_out %0d, y_out %0d", i_x_out, i_y_out);
            error_count++;
        end else begin
            want = averages_due.pop_front();
            checked_count++;
            if (i_x_out !== want.x) begin
                $error("x_out: expected %0d, got %0d", want.x, i_x_out);
                error_count++;
            end
            if (i_y_out !== want.y) begin
                $error("y_out: expected %0d, got %0d", want.y, i_y_out);
                error_count++;
            end
            if (i_x_out_ok !== want.x_ok) begin
                $error("x_out_ok: expected %0b, got %0b", want.x_ok, i_x_out_ok);
                error_count++;
            end
            if (i_y_out_ok !== want.y_ok) begin
                $error("y_out_ok: expected %0b, got %0b", want.y_ok, i_y_out_ok);
                error_count++;
            end
        end
    endtask

    initial begin
        checked_count = 0;
        error_count   = 0;
        reset_window_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_window_state();
        end else begin
            if (psel && penable && pwrite && pready) begin
                apply_reg_write(paddr[APB_ADDR_W-1:2], pwdata);
            end
            if (i_in_valid && i_in_ready) begin
                predict_average(i_x_sample, i_y_sample, i_x_ok, i_y_ok, i_series_start);
            end
            if (i_out_valid && i_out_ready) begin
                check_average();
            end
        end
        o_pending <= averages_due.size();
        o_checked <= checked_count;
        o_errors  <= error_count;
    end

endmodule

// File: dv/tb_top.sv
// top of the xy moving average testbench: clock, reset, register setup, sample stimulus
// and result back-pressure; verdict comes from the failure count of xyma_checker
// depends on xyma_pkg, xyma_checker and the xy_moving_average RTL
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import xyma_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int CLK_HALF     = 1;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 120;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 8;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic signed [SW-1:0] S_MAX     = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN     = {1'b1, {(SW-1){1'b0}}};

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic signed [SW-1:0]  i_x_sample     = '0;
    logic signed [SW-1:0]  i_y_sample     = '0;
    logic                  i_x_ok         = 1'b0;
    logic                  i_y_ok         = 1'b0;
    logic                  i_series_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic signed [SW-1:0]  o_x_out;
    logic signed [SW-1:0]  o_y_out;
    logic                  o_x_out_ok;
    logic                  o_y_out_ok;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int checked;
    int errors;
    int burst_left    = 0;
    int samples_sent  = 0;
    int settings_run  = 0;
    int stall_mode    = 0;
    int stall_left    = 0;
    int stall_tick    = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    xy_moving_average u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_x_ok         (i_x_ok),
        .i_y_ok         (i_y_ok),
        .i_series_start (i_series_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_x_out_ok     (o_x_out_ok),
        .o_y_out_ok     (o_y_out_ok),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    xyma_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_x_ok         (i_x_ok),
        .i_y_ok         (i_y_ok),
        .i_series_start (i_series_start),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_x_out        (o_x_out),
        .i_y_out        (o_y_out),
        .i_x_out_ok     (o_x_out_ok),
        .i_y_out_ok     (o_y_out_ok),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_errors       (errors)
    );

    // result back-pressure, switching between stall patterns
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
        end
        stall_left = stall_left - 1;
        stall_tick = stall_tick + 1;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ((stall_tick % 7) < 3);
        endcase
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
                               input logic x_ok, input logic y_ok, input logic start);
        i_in_valid     <= 1'b1;
        i_x_sample     <= x;
        i_y_sample     <= y;
        i_x_ok         <= x_ok;
        i_y_ok         <= y_ok;
        i_series_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(13, 60)) @(posedge i_clk);
            else repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // quiet the sample port, let every result out, then give the block time to settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [SPAN_REG_W-1:0] span, input logic avg, input logic xidx);
        logic [APB_DATA_W-1:0] value;
        wait_drained();
        value                   = $urandom();
        value[SPAN_REG_W-1:0]   = span;
        write_reg(REG_SPAN, value);
        value                   = $urandom();
        value[0]                = avg;
        write_reg(REG_AVG_X, value);
        value                   = $urandom();
        value[0]                = xidx;
        write_reg(REG_X_INDEX, value);
        if ($urandom_range(0, 1) == 0) write_reg(REG_SPARE, $urandom());
        settings_run++;
    endtask

    function automatic logic signed [SW-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SW'($urandom_range(0, 255));
            3:       return '1;
            4:       return S_MIN + SW'($urandom_range(0, 255));
            5:       return S_MAX - SW'($urandom_range(0, 255));
            default: return SW'($urandom());
        endcase
    endfunction

    task automatic random_item(input int unsigned span);
        logic x_ok;
        logic y_ok;
        logic start;
        x_ok = 1'b1;
        y_ok = 1'b1;
        if ($urandom_range(0, 2 * span + 6) == 0) begin
            case ($urandom_range(0, 2))
                0:       x_ok = 1'b0;
                1:       y_ok = 1'b0;
                default: begin
                    x_ok = 1'b0;
                    y_ok = 1'b0;
                end
            endcase
        end
        start = ($urandom_range(0, 4 * span + 30) == 0);
        send_sample(random_value(), random_value(), x_ok, y_ok, start);
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        logic [SPAN_REG_W-1:0] span;
        logic                  avg;
        logic                  xidx;
        int unsigned           span_eff;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: span 3, x averaged
        send_sample(S_MAX, S_MAX, 1'b1, 1'b1, 1'b1);
        send_sample(S_MAX, S_MIN, 1'b1, 1'b1, 1'b0);
        send_sample(S_MIN, S_MIN, 1'b1, 1'b1, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b1, 1'b1, 1'b0);
        send_sample(-7, 7, 1'b1, 1'b1, 1'b0);
        send_sample(-8, -9, 1'b1, 1'b1, 1'b0);
        send_sample(3, 4, 1'b0, 1'b1, 1'b0);
        send_sample(3, 4, 1'b1, 1'b0, 1'b0);
        send_sample(1, 1, 1'b1, 1'b1, 1'b0);
        send_sample(2, -2, 1'b1, 1'b1, 1'b0);
        send_sample(5, -5, 1'b1, 1'b1, 1'b0);
        send_sample(0, 0, 1'b1, 1'b1, 1'b1);

        // index as x, current x passed, span below range
        wait_drained();
        write_reg(REG_AVG_X, 32'd0);
        write_reg(REG_X_INDEX, 32'd1);
        write_reg(REG_SPAN, 32'd0);
        write_reg(REG_SPARE, '1);
        settings_run++;
        send_sample(S_MAX, 1, 1'b0, 1'b1, 1'b1);
        send_sample(S_MIN, -1, 1'b0, 1'b1, 1'b0);
        send_sample(0, S_MIN, 1'b1, 1'b0, 1'b0);
        send_sample(0, S_MAX, 1'b0, 1'b1, 1'b0);
        send_sample(0, S_MAX, 1'b0, 1'b1, 1'b0);

        // index averaged
        wait_drained();
        write_reg(REG_AVG_X, 32'd1);
        settings_run++;
        send_sample(S_MIN, random_value(), 1'b0, 1'b1, 1'b0);
        send_sample(S_MAX, random_value(), 1'b1, 1'b1, 1'b0);
        send_sample(0, random_value(), 1'b0, 1'b1, 1'b0);

        // span above range, refill not complete
        wait_drained();
        write_reg(REG_SPAN, 32'd127);
        write_reg(REG_X_INDEX, 32'd0);
        settings_run++;
        send_sample(S_MAX, S_MIN, 1'b1, 1'b1, 1'b1);
        send_sample(S_MIN, S_MAX, 1'b1, 1'b1, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin span = 7'd2;   avg = 1'b1; xidx = 1'b0; end
                1: begin span = 7'd64;  avg = 1'b1; xidx = 1'b0; end
                2: begin span = 7'd127; avg = 1'b0; xidx = 1'b0; end
                3: begin span = 7'd0;   avg = 1'b1; xidx = 1'b1; end
                4: begin span = 7'd5;   avg = 1'b0; xidx = 1'b1; end
                5: begin span = 7'd1;   avg = 1'b0; xidx = 1'b0; end
                default: begin
                    span = SPAN_REG_W'($urandom_range(2, 64));
                    avg  = 1'($urandom_range(0, 1));
                    xidx = 1'($urandom_range(0, 1));
                end
            endcase
            span_eff = (span < 2) ? 2 : ((span > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : span);
            configure(span, avg, xidx);
            for (int n = 0; n < PHASE_ITEMS; n++) random_item(span_eff);
        end

        wait_drained();
        $display("tb_top: %0d samples sent under %0d register settings, %0d results compared",
                 samples_sent, settings_run, checked);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
